// ----- design/i2p_pkg.sv -----
package i2p_pkg;

  // Default sizes.
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_MAX_LENGTH  = 1024;

  // Result field widths.
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;
  localparam int POS_W  = 10;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // Characters the converter recognises.
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  // Operator stack entry codes.
  localparam int CODE_W = 3;
  localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_OPEN  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_PLUS  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_MINUS = 3'd3;
  localparam logic [CODE_W-1:0] CODE_STAR  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_SLASH = 3'd5;

  // Class of the previous character.
  typedef enum logic [1:0] {
    CLS_START = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_OPER  = 2'd2,
    CLS_OTHER = 2'd3
  } cls_t;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_LATCH      = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_EMIT_DIGIT = 3'd3,
    CMD_EMIT_SPACE = 3'd4,
    CMD_BODY       = 3'd5,
    CMD_POP_CHAR   = 3'd6,
    CMD_POP_SPACE  = 3'd7
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_end;
    logic err_seen;
    logic is_digit;
    logic in_number;
    logic pop_more;
    logic body_emits;
    logic out_free;
  } dp_status_t;

  // Operator character to stack code; zero for anything else.
  function automatic logic [CODE_W-1:0] op_code(input logic [CHAR_W-1:0] c);
    logic [CODE_W-1:0] code;
    code = CODE_NONE;
    if (c == CH_PLUS) code = CODE_PLUS;
    else if (c == CH_MINUS) code = CODE_MINUS;
    else if (c == CH_STAR) code = CODE_STAR;
    else if (c == CH_SLASH) code = CODE_SLASH;
    return code;
  endfunction

  // Operator priority; the open parenthesis has the lowest.
  function automatic logic [1:0] code_prio(input logic [CODE_W-1:0] code);
    logic [1:0] prio;
    case (code)
      CODE_PLUS, CODE_MINUS: prio = 2'd1;
      CODE_STAR, CODE_SLASH: prio = 2'd2;
      default:               prio = 2'd0;
    endcase
    return prio;
  endfunction

  // Stack code back to its character.
  function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      CODE_OPEN:  c = CH_OPEN;
      CODE_PLUS:  c = CH_PLUS;
      CODE_MINUS: c = CH_MINUS;
      CODE_STAR:  c = CH_STAR;
      CODE_SLASH: c = CH_SLASH;
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/i2p_ctrl.sv -----
module i2p_ctrl import i2p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LEAD = 5'b00010,
    S_BODY = 5'b00100,
    S_POPC = 5'b01000,
    S_POPS = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Items are taken only between items.
  assign item_stall = (state != S_IDLE);

  // Sequencing of one item; every emitting step waits for a free output register.
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd        = CMD_LATCH;
          state_next = S_LEAD;
        end
      end
      S_LEAD: begin
        if (status.err_seen) begin
          if (status.item_end) cmd = CMD_CLEAR;
          state_next = S_IDLE;
        end else if (!status.item_end && status.is_digit) begin
          if (status.out_free) begin
            cmd        = CMD_EMIT_DIGIT;
            state_next = S_IDLE;
          end
        end else if (status.in_number) begin
          if (status.out_free) begin
            cmd        = CMD_EMIT_SPACE;
            state_next = S_BODY;
          end
        end else begin
          state_next = S_BODY;
        end
      end
      S_BODY: begin
        if (status.pop_more) begin
          state_next = S_POPC;
        end else if (!status.body_emits || status.out_free) begin
          cmd        = CMD_BODY;
          state_next = S_IDLE;
        end
      end
      S_POPC: begin
        if (status.out_free) begin
          cmd        = CMD_POP_CHAR;
          state_next = S_POPS;
        end
      end
      S_POPS: begin
        if (status.out_free) begin
          cmd        = CMD_POP_SPACE;
          state_next = S_BODY;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/i2p_datapath.sv -----
module i2p_datapath import i2p_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op,
  input  logic [CHAR_W-1:0] ch,
  input  cmd_t              cmd,
  output dp_status_t        status,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic [KIND_W-1:0] kind,
  output logic [POS_W-1:0]  error_pos,
  output logic              last
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int XW = $clog2(MAX_LENGTH);
  localparam logic [CW-1:0] FULL    = CW'(STACK_DEPTH);
  localparam logic [XW-1:0] IDX_MAX = XW'(MAX_LENGTH - 1);

  // Held item and its character position.
  logic              item_end;
  logic [CHAR_W-1:0] item_ch;
  logic [XW-1:0]     pos;

  // Conversion state.
  logic [CODE_W-1:0] stack [STACK_DEPTH];
  logic [CW-1:0]     stack_count, stack_count_next;
  logic [XW-1:0]     char_index, char_index_next;
  cls_t              prev_class, prev_class_next;
  logic              in_number, in_number_next;
  logic              error_seen, error_seen_next;

  logic              push_en;
  logic [CODE_W-1:0] push_val;

  // Output register.
  logic              load;
  logic [CHAR_W-1:0] char_next;
  logic [KIND_W-1:0] kind_next;
  logic [POS_W-1:0]  pos_next;
  logic              last_next;

  // Decode of the held character and of the stack top.
  logic [CW-1:0]     cnt_dec;
  logic [CODE_W-1:0] top_code;
  logic [CODE_W-1:0] item_code;
  logic              is_digit, is_ws, is_open, is_close, is_op, is_unary;
  logic              not_empty, full, top_open;
  logic              pop_more, body_emits, body_silent;

  always_comb begin
    cnt_dec   = stack_count - CW'(1);
    top_code  = stack[cnt_dec[IW-1:0]];
    item_code = op_code(item_ch);
    is_digit  = (item_ch >= CH_ZERO && item_ch <= CH_NINE) || item_ch == CH_DOT;
    is_ws     = item_ch == CH_SPACE || (item_ch >= CH_TAB && item_ch <= CH_CR);
    is_open   = item_ch == CH_OPEN;
    is_close  = item_ch == CH_CLOSE;
    is_op     = item_code != CODE_NONE;
    is_unary  = is_op && prev_class != CLS_OTHER;
    not_empty = stack_count != '0;
    full      = stack_count == FULL;
    top_open  = top_code == CODE_OPEN;
  end

  // What the remaining work of the item does: pop an operator, or finish.
  always_comb begin
    pop_more   = 1'b0;
    body_emits = 1'b1;
    if (item_end) begin
      pop_more = not_empty && !top_open;
    end else if (is_ws) begin
      body_emits = 1'b0;
    end else if (is_open) begin
      body_emits = full;
    end else if (is_close) begin
      pop_more   = not_empty && !top_open;
      body_emits = !not_empty;
    end else if (is_op && !is_unary) begin
      pop_more   = not_empty && (code_prio(top_code) >= code_prio(item_code));
      body_emits = full;
    end
    body_silent = !body_emits && !pop_more;
  end

  assign status = '{
    item_end:   item_end,
    err_seen:   error_seen,
    is_digit:   is_digit,
    in_number:  in_number,
    pop_more:   pop_more,
    body_emits: body_emits,
    out_free:   !result_valid || !result_stall
  };

  // Next state and result for each command.
  always_comb begin
    stack_count_next = stack_count;
    char_index_next  = char_index;
    prev_class_next  = prev_class;
    in_number_next   = in_number;
    error_seen_next  = error_seen;
    push_en          = 1'b0;
    push_val         = CODE_OPEN;
    load             = 1'b0;
    char_next        = '0;
    kind_next        = KIND_CHAR;
    pos_next         = '0;
    last_next        = 1'b0;
    case (cmd)
      CMD_LATCH: begin
        if (!op && !error_seen && char_index != IDX_MAX) begin
          char_index_next = char_index + XW'(1);
        end
      end
      CMD_CLEAR: begin
        stack_count_next = '0;
        char_index_next  = '0;
        prev_class_next  = CLS_START;
        in_number_next   = 1'b0;
        error_seen_next  = 1'b0;
      end
      CMD_EMIT_DIGIT: begin
        load            = 1'b1;
        char_next       = item_ch;
        last_next       = 1'b1;
        in_number_next  = 1'b1;
        prev_class_next = CLS_OTHER;
      end
      CMD_EMIT_SPACE: begin
        load           = 1'b1;
        char_next      = CH_SPACE;
        last_next      = body_silent;
        in_number_next = 1'b0;
      end
      CMD_POP_CHAR: begin
        load             = 1'b1;
        char_next        = code_char(top_code);
        stack_count_next = cnt_dec;
      end
      CMD_POP_SPACE: begin
        load      = 1'b1;
        char_next = CH_SPACE;
        last_next = body_silent;
      end
      CMD_BODY: begin
        if (item_end) begin
          // End of expression: an open parenthesis left on the stack is an error.
          load             = 1'b1;
          last_next        = 1'b1;
          kind_next        = not_empty ? KIND_ERROR : KIND_DONE;
          stack_count_next = '0;
          char_index_next  = '0;
          prev_class_next  = CLS_START;
          in_number_next   = 1'b0;
          error_seen_next  = 1'b0;
        end else if (is_ws) begin
          prev_class_next = CLS_OTHER;
        end else if (is_open && !full) begin
          push_en          = 1'b1;
          push_val         = CODE_OPEN;
          stack_count_next = stack_count + CW'(1);
          prev_class_next  = CLS_OPEN;
        end else if (is_close && not_empty) begin
          stack_count_next = cnt_dec;
          prev_class_next  = CLS_OTHER;
        end else if (is_unary) begin
          load            = 1'b1;
          char_next       = item_ch;
          last_next       = 1'b1;
          in_number_next  = 1'b1;
          prev_class_next = CLS_OPER;
        end else if (is_op && !full) begin
          push_en          = 1'b1;
          push_val         = item_code;
          stack_count_next = stack_count + CW'(1);
          prev_class_next  = CLS_OPER;
        end else begin
          // Overflow, unmatched close or illegal character.
          load            = 1'b1;
          last_next       = 1'b1;
          kind_next       = KIND_ERROR;
          pos_next        = POS_W'(pos);
          error_seen_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= '0;
      char_index   <= '0;
      prev_class   <= CLS_START;
      in_number    <= 1'b0;
      error_seen   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      stack_count <= stack_count_next;
      char_index  <= char_index_next;
      prev_class  <= prev_class_next;
      in_number   <= in_number_next;
      error_seen  <= error_seen_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers: held item, stack entries and the result.
  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) begin
      item_end <= op;
      item_ch  <= ch;
      pos      <= char_index;
    end
    if (push_en) begin
      stack[stack_count[IW-1:0]] <= push_val;
    end
    if (load) begin
      out_char  <= char_next;
      kind      <= kind_next;
      error_pos <= pos_next;
      last      <= last_next;
    end
  end

endmodule

// ----- design/infix_to_postfix_converter_top.sv -----
// Streaming infix to postfix converter. Each transfer on the item channel brings one
// expression character (op low) or an end-of-expression mark (op high); the result
// channel returns the postfix characters, a finished or error code, and last on the
// final result of each item. Items are handled one at a time: a digit passes through
// the lead step only, any other character through the lead and body steps, and a
// character or end mark that arrives after an error through the lead step only.
// Every operator popped from the stack passes, with its trailing space, through the
// single output register; the controller then returns to the body step to decide
// whether to pop again. Stalls on the result channel hold every emitting step.
module infix_to_postfix_converter_top import i2p_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              op,
  input  logic [CHAR_W-1:0] ch,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic [KIND_W-1:0] kind,
  output logic [POS_W-1:0]  error_pos,
  output logic              last
);

  cmd_t       cmd;
  dp_status_t status;

  // Sequencer for one item.
  i2p_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Operator stack, counters and output register.
  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .ch           (ch),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_char     (out_char),
    .kind         (kind),
    .error_pos    (error_pos),
    .last         (last)
  );

endmodule
